// ===== rtl/ais_tx_pkg.sv =====
// ----------------------------------------------------------------------------
// ais_tx_pkg
// Shared types, constants and the control store of the AIS HDLC transmit
// framer.
// ----------------------------------------------------------------------------
package ais_tx_pkg;

  localparam int PRE_BITS    = 40;
  localparam int BUDGET_MAX  = 32;
  localparam int STUFF_MAX   = 63;
  localparam int RUN_LIMIT   = 5;

  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [39:0] PREAMBLE     = 40'h00_5555_557E;
  localparam logic [7:0]  FLAG_BYTE    = 8'h7E;
  localparam logic [5:0]  BUDGET_RESET = 6'd24;

  typedef logic [2:0] step_t;

  localparam step_t S_IDLE  = 3'd0;
  localparam step_t S_PRE   = 3'd1;
  localparam step_t S_BODY  = 3'd2;
  localparam step_t S_FCS   = 3'd3;
  localparam step_t S_FLAG  = 3'd4;
  localparam step_t S_PAD   = 3'd5;
  localparam step_t S_ALIGN = 3'd6;
  localparam step_t S_DONE  = 3'd7;

  typedef enum logic [2:0] {
    SRC_NONE = 3'd0,
    SRC_PRE  = 3'd1,
    SRC_DATA = 3'd2,
    SRC_FCS  = 3'd3,
    SRC_FLAG = 3'd4,
    SRC_ZERO = 3'd5
  } src_t;

  typedef enum logic [2:0] {
    LEN_8     = 3'd0,
    LEN_16    = 3'd1,
    LEN_40    = 3'd2,
    LEN_PAD   = 3'd3,
    LEN_ALIGN = 3'd4
  } len_t;

  typedef enum logic [1:0] {
    BR_NONE  = 2'd0,
    BR_LAST  = 2'd1,
    BR_START = 2'd2
  } br_t;

  typedef struct packed {
    src_t  src;
    len_t  len;
    logic  crc_en;
    logic  stuff_en;
    logic  pad_next;
    logic  wait_in;
    logic  clear;
    logic  mark_start;
    br_t   br;
    step_t nxt;
    step_t alt;
  } uword_t;

  typedef struct packed {
    uword_t     w;
    logic [5:0] idx;
    logic       fin;
    logic       load;
  } ctrl_t;

  typedef struct packed {
    logic       adv;
    logic       empty;
    logic [5:0] pad_n;
  } stat_t;

  function automatic uword_t ucode(input step_t addr);
    uword_t w;
    w = '{src: SRC_NONE, len: LEN_8, crc_en: 1'b0, stuff_en: 1'b0, pad_next: 1'b0,
          wait_in: 1'b0, clear: 1'b0, mark_start: 1'b0, br: BR_NONE,
          nxt: S_IDLE, alt: S_IDLE};
    case (addr)
      S_IDLE: begin
        w.wait_in = 1'b1;
        w.br      = BR_START;
        w.nxt     = S_PRE;
        w.alt     = S_BODY;
      end
      S_PRE: begin
        w.src        = SRC_PRE;
        w.len        = LEN_40;
        w.mark_start = 1'b1;
        w.nxt        = S_BODY;
      end
      S_BODY: begin
        w.src      = SRC_DATA;
        w.len      = LEN_8;
        w.crc_en   = 1'b1;
        w.stuff_en = 1'b1;
        w.br       = BR_LAST;
        w.nxt      = S_FCS;
        w.alt      = S_IDLE;
      end
      S_FCS: begin
        w.src      = SRC_FCS;
        w.len      = LEN_16;
        w.stuff_en = 1'b1;
        w.nxt      = S_FLAG;
      end
      S_FLAG: begin
        w.src      = SRC_FLAG;
        w.len      = LEN_8;
        w.pad_next = 1'b1;
        w.nxt      = S_PAD;
      end
      S_PAD: begin
        w.src = SRC_ZERO;
        w.len = LEN_PAD;
        w.nxt = S_ALIGN;
      end
      S_ALIGN: begin
        w.src = SRC_ZERO;
        w.len = LEN_ALIGN;
        w.nxt = S_DONE;
      end
      S_DONE: begin
        w.clear = 1'b1;
        w.nxt   = S_IDLE;
      end
      default: begin
        w.nxt = S_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic [5:0] last_idx(input len_t len, input logic [5:0] pad_n);
    logic [5:0] r;
    case (len)
      LEN_8:   r = 6'd7;
      LEN_16:  r = 6'd15;
      LEN_40:  r = 6'(PRE_BITS - 1);
      LEN_PAD: r = pad_n - 6'd1;
      default: r = '1;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/ais_tx_useq.sv =====
// ----------------------------------------------------------------------------
// ais_tx_useq
// Micro-sequencer: step counter, control store lookup, bit index and
// branch logic. Owns the input handshake and the frame-started flag.
// ----------------------------------------------------------------------------
module ais_tx_useq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                last_byte,
  input  ais_tx_pkg::stat_t   stat,
  output ais_tx_pkg::ctrl_t   ctrl
);

  ais_tx_pkg::step_t  upc, upc_next;
  logic [5:0]         idx, idx_next;
  logic               started, started_next;
  logic               last_r, last_r_next;
  ais_tx_pkg::uword_t w;
  logic               at_end;
  logic               take_alt;

  assign w        = ais_tx_pkg::ucode(upc);
  assign in_ready = w.wait_in;
  assign at_end   = (w.len != ais_tx_pkg::LEN_ALIGN) &&
                    (idx == ais_tx_pkg::last_idx(w.len, stat.pad_n));

  always_comb begin
    case (w.br)
      ais_tx_pkg::BR_LAST:  take_alt = !last_r;
      ais_tx_pkg::BR_START: take_alt = started;
      default:              take_alt = 1'b0;
    endcase
  end

  always_comb begin
    ctrl.w      = w;
    ctrl.idx    = idx;
    ctrl.load   = w.wait_in && in_valid;
    ctrl.fin    = (w.len == ais_tx_pkg::LEN_ALIGN) ||
                  (at_end && ((w.len == ais_tx_pkg::LEN_PAD) ||
                              (w.pad_next && (stat.pad_n == '0))));
  end

  always_comb begin
    upc_next     = upc;
    idx_next     = idx;
    started_next = started;
    last_r_next  = last_r;
    if (w.wait_in) begin
      if (in_valid) begin
        upc_next    = take_alt ? w.alt : w.nxt;
        idx_next    = '0;
        last_r_next = last_byte;
      end
    end else if (w.clear) begin
      upc_next     = w.nxt;
      started_next = 1'b0;
    end else if (stat.empty) begin
      upc_next = w.nxt;
      idx_next = '0;
    end else if (stat.adv) begin
      if (at_end) begin
        upc_next = take_alt ? w.alt : w.nxt;
        idx_next = '0;
        if (w.mark_start) begin
          started_next = 1'b1;
        end
      end else begin
        idx_next = idx + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc     <= ais_tx_pkg::S_IDLE;
      idx     <= '0;
      started <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      upc     <= upc_next;
      idx     <= idx_next;
      started <= started_next;
      last_r  <= last_r_next;
    end
  end

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    (upc == ais_tx_pkg::S_DONE) |=> (upc == ais_tx_pkg::S_IDLE) && !started)
    else $error("frame close did not return to idle");

  a_pre_once: assert property (@(posedge clk) disable iff (rst)
    (upc == ais_tx_pkg::S_PRE) |-> !started)
    else $error("preamble sent inside a started frame");

endmodule

// ===== rtl/ais_tx_dpath.sv =====
// ----------------------------------------------------------------------------
// ais_tx_dpath
// Bit datapath: bit source select, CRC-CCITT, zero insertion, NRZI,
// byte packer, output register and pad budget register.
// ----------------------------------------------------------------------------
module ais_tx_dpath (
  input  logic               clk,
  input  logic               rst,
  input  ais_tx_pkg::ctrl_t  ctrl,
  output ais_tx_pkg::stat_t  stat,
  input  logic [7:0]         payload_byte,
  input  logic               cfg_we,
  input  logic [5:0]         cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         line_byte,
  output logic               frame_end
);

  logic [7:0]  data_r;
  logic [5:0]  pad_budget;
  logic [15:0] crc;
  logic [2:0]  ones_run;
  logic        pend;
  logic        level;
  logic [7:0]  pack_shift;
  logic [2:0]  pack_count;
  logic [5:0]  stuffed;

  logic        b;
  logic        tx;
  logic        lvl_new;
  logic        first;
  logic        sets_pend;
  logic        emit;
  logic        stall;
  logic        go;
  logic        out_load;
  logic        fb;
  logic [5:0]  budget;
  logic [5:0]  pad_n;
  logic        empty;
  logic        adv;

  always_comb begin
    case (ctrl.w.src)
      ais_tx_pkg::SRC_PRE:  b = ais_tx_pkg::PREAMBLE[6'(ais_tx_pkg::PRE_BITS - 1) - ctrl.idx];
      ais_tx_pkg::SRC_DATA: b = data_r[ctrl.idx[2:0]];
      ais_tx_pkg::SRC_FCS:  b = ~crc[4'd15 - ctrl.idx[3:0]];
      ais_tx_pkg::SRC_FLAG: b = ais_tx_pkg::FLAG_BYTE[3'd7 - ctrl.idx[2:0]];
      default:              b = 1'b0;
    endcase
  end

  always_comb begin
    budget = (pad_budget > 6'(ais_tx_pkg::BUDGET_MAX)) ?
             6'(ais_tx_pkg::BUDGET_MAX) : pad_budget;
    pad_n  = (stuffed <= budget) ? budget - stuffed : '0;
    empty  = ((ctrl.w.len == ais_tx_pkg::LEN_PAD) && (pad_n == '0)) ||
             ((ctrl.w.len == ais_tx_pkg::LEN_ALIGN) && (pack_count == '0));
  end

  assign tx        = pend ? 1'b0 : b;
  assign first     = (ctrl.w.src == ais_tx_pkg::SRC_PRE) && (ctrl.idx == '0);
  assign lvl_new   = first ? 1'b1 : (tx ? level : ~level);
  assign sets_pend = ctrl.w.stuff_en && !pend && b &&
                     (ones_run == 3'(ais_tx_pkg::RUN_LIMIT - 1));
  assign emit      = (ctrl.w.src != ais_tx_pkg::SRC_NONE) && !empty;
  assign stall     = emit && (pack_count == 3'd7) && out_valid && !out_ready;
  assign go        = emit && !stall;
  assign out_load  = go && (pack_count == 3'd7);
  assign adv       = go && (pend || !sets_pend);
  assign fb        = crc[15] ^ b;
  assign stat      = '{adv: adv, empty: empty, pad_n: pad_n};

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      data_r <= payload_byte;
    end
    if (out_load) begin
      line_byte <= {pack_shift[6:0], lvl_new};
      frame_end <= ctrl.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_budget <= ais_tx_pkg::BUDGET_RESET;
    end else if (cfg_we) begin
      pad_budget <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.w.clear) begin
      crc        <= ais_tx_pkg::CRC_INIT;
      ones_run   <= '0;
      pend       <= 1'b0;
      level      <= 1'b1;
      pack_shift <= '0;
      pack_count <= '0;
      stuffed    <= '0;
    end else if (go) begin
      level <= lvl_new;
      if (pack_count == 3'd7) begin
        pack_shift <= '0;
        pack_count <= '0;
      end else begin
        pack_shift <= {pack_shift[6:0], lvl_new};
        pack_count <= pack_count + 3'd1;
      end
      if (pend) begin
        pend     <= 1'b0;
        ones_run <= '0;
        if (stuffed != 6'(ais_tx_pkg::STUFF_MAX)) begin
          stuffed <= stuffed + 6'd1;
        end
      end else if (ctrl.w.stuff_en) begin
        if (sets_pend) begin
          pend     <= 1'b1;
          ones_run <= '0;
        end else if (b) begin
          ones_run <= ones_run + 3'd1;
        end else begin
          ones_run <= '0;
        end
      end
      if (ctrl.w.crc_en && !pend) begin
        crc <= {crc[14:0], 1'b0} ^ (fb ? ais_tx_pkg::CRC_POLY : 16'h0000);
      end
    end
  end

  a_pend_in_stuff: assert property (@(posedge clk) disable iff (rst)
    pend |-> ctrl.w.stuff_en)
    else $error("stuff bit pending outside a stuffed section");

  a_end_aligned: assert property (@(posedge clk) disable iff (rst)
    ctrl.w.clear |-> (pack_count == '0) && !pend)
    else $error("frame closed off a byte boundary");

endmodule

// ===== rtl/ais_hdlc_tx_framer.sv =====
// ----------------------------------------------------------------------------
// ais_hdlc_tx_framer
// HDLC transmit framer with CRC-CCITT, zero insertion and NRZI line coding,
// emitting packed line bytes, earliest level in bit 7.
//
//   channel  direction  handshake            word
//   in       in         in_valid/in_ready    payload_byte, last_byte
//   out      out        out_valid/out_ready  line_byte, frame_end
//   cfg      in         cfg_we               cfg_data (pad_budget)
//
// One line bit per cycle from the bit datapath while the output stall below
// does not hold it. Each payload byte is taken in idle; each stuffed zero
// adds one line bit. A frame adds 40 preamble bits up front and, after the
// last byte, 16 CRC + 8 flag + pad + alignment bits and the closing steps.
// Reset is synchronous; pad_budget resets to 24.
// A full output register stalls the bit engine on the bit that would
// complete the next line byte.
// ----------------------------------------------------------------------------
module ais_hdlc_tx_framer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] payload_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] line_byte,
  output logic       frame_end,
  input  logic       cfg_we,
  input  logic [5:0] cfg_data
);

  ais_tx_pkg::ctrl_t ctrl;
  ais_tx_pkg::stat_t stat;

  ais_tx_useq u_useq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .last_byte (last_byte),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  ais_tx_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .payload_byte (payload_byte),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .line_byte    (line_byte),
    .frame_end    (frame_end)
  );

endmodule
